/* rtl/pib_pkg.sv */
// ----------------------------------------------------------------------------
// Particle integrate-and-bin: shared definitions
// Widths, register indexes, reset values and the item types that pass between
// the front end, the queue and the histogram back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pib_pkg;

  localparam int AXES        = 3;
  localparam int DATA_W      = 24;   // Q16.8 position and velocity
  localparam int EXT_W       = 23;   // half extent registers
  localparam int SCALE_W     = 24;   // Q0.24 cell scale registers
  localparam int CFG_IDX_W   = 3;
  localparam int CELL_IDX_W  = 12;
  localparam int COUNT_W     = 16;
  localparam int NUM_ENTRIES = 4096;
  localparam int EPOCH_W     = 8;
  localparam int QUEUE_DEPTH = 4;

  // Velocity damping: 230/256 with round-half-up.
  localparam int DAMP_NUM   = 230;
  localparam int DAMP_ROUND = 128;
  localparam int DAMP_SHIFT = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_DEPTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE_Z = 3'd5;

  localparam logic [EXT_W-1:0]   HALF_RESET  = 23'd32768;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd4096;

  typedef logic signed [DATA_W-1:0] pib_fix_t;

  typedef struct packed {
    logic                    clear;
    pib_fix_t [AXES-1:0]     pos;
    pib_fix_t [AXES-1:0]     vel;
    logic [CELL_IDX_W-1:0]   idx;
  } pib_item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [COUNT_W-1:0] count;
  } pib_entry_t;

endpackage

`default_nettype wire

/* rtl/pib_if.sv */
// ----------------------------------------------------------------------------
// Particle integrate-and-bin: channel interfaces
// Valid/ready channels for particle items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pib_in_if import pib_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] pos_z;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;
  logic signed [DATA_W-1:0] vel_z;

  modport source (output valid, mode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                output ready);
endinterface

interface pib_out_if import pib_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_pos_x;
  logic signed [DATA_W-1:0] new_pos_y;
  logic signed [DATA_W-1:0] new_pos_z;
  logic signed [DATA_W-1:0] new_vel_x;
  logic signed [DATA_W-1:0] new_vel_y;
  logic signed [DATA_W-1:0] new_vel_z;
  logic [CELL_IDX_W-1:0]    cell_index;
  logic [COUNT_W-1:0]       cell_count;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, cell_index, cell_count, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                new_vel_y, new_vel_z, cell_index, cell_count, output ready);
endinterface

interface pib_cfg_if import pib_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCALE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/pib_front.sv */
// ----------------------------------------------------------------------------
// Particle integrate-and-bin: front end
// Holds the configuration registers and runs the three-stage arithmetic
// pipeline that integrates, damps, clamps and bins each particle.
// ----------------------------------------------------------------------------
`default_nettype none

module pib_front import pib_pkg::*; #(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input  logic      clk,
  input  logic      rst,
  pib_in_if.sink    particle,
  pib_cfg_if.sink   cfg,
  input  logic      sweep_busy,
  input  logic      q_ready,
  output logic      q_push,
  output pib_item_t q_item
);

  localparam int CELLS_XY  = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
  localparam int CELLS_MAX = (CELLS_XY > CELLS_Z) ? CELLS_XY : CELLS_Z;
  localparam int CW        = (CELLS_MAX > 1) ? $clog2(CELLS_MAX) : 1;
  localparam int LIN_W     = AXES * CW;
  localparam int CALC_W    = (LIN_W > CELL_IDX_W) ? LIN_W : CELL_IDX_W;
  localparam int SUM_W     = DATA_W + 1;
  localparam int VPROD_W   = DATA_W + 9;
  localparam int PROD_W    = DATA_W + SCALE_W;
  localparam int AXIS_CELLS [AXES] = '{CELLS_X, CELLS_Y, CELLS_Z};

  logic [EXT_W-1:0]   half_ext   [AXES];
  logic [SCALE_W-1:0] cell_scale [AXES];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        half_ext[a]   <= HALF_RESET;
        cell_scale[a] <= SCALE_RESET;
      end
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_HALF_WIDTH:   half_ext[0]   <= cfg.data[EXT_W-1:0];
        REG_HALF_HEIGHT:  half_ext[1]   <= cfg.data[EXT_W-1:0];
        REG_HALF_DEPTH:   half_ext[2]   <= cfg.data[EXT_W-1:0];
        REG_CELL_SCALE_X: cell_scale[0] <= cfg.data;
        REG_CELL_SCALE_Y: cell_scale[1] <= cfg.data;
        REG_CELL_SCALE_Z: cell_scale[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  pib_fix_t in_pos [AXES];
  pib_fix_t in_vel [AXES];

  assign in_pos[0] = particle.pos_x;
  assign in_pos[1] = particle.pos_y;
  assign in_pos[2] = particle.pos_z;
  assign in_vel[0] = particle.vel_x;
  assign in_vel[1] = particle.vel_y;
  assign in_vel[2] = particle.vel_z;

  logic adv;
  logic accept;
  logic v1, v2, v3;

  assign adv            = !v3 || q_ready;
  assign particle.ready = adv && !sweep_busy;
  assign accept         = particle.valid && particle.ready;
  assign q_push         = v3 && q_ready;

  // Stage 1: raw position sum and damped velocity.
  logic signed [SUM_W-1:0]   sum_c   [AXES];
  logic signed [VPROD_W-1:0] vprod_c [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_c[a]   = SUM_W'(in_pos[a]) + SUM_W'(in_vel[a]);
      vprod_c[a] = VPROD_W'(in_vel[a]) * VPROD_W'(DAMP_NUM) + VPROD_W'(DAMP_ROUND);
    end
  end

  logic                    s1_clear;
  logic signed [SUM_W-1:0] s1_sum [AXES];
  pib_fix_t                s1_vel [AXES];

  // Stage 2: clamp to the half extent and shift into the positive range.
  logic signed [SUM_W-1:0] half_c  [AXES];
  logic signed [SUM_W-1:0] clamp_c [AXES];
  logic signed [SUM_W-1:0] shift_c [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      half_c[a] = $signed({2'b00, half_ext[a]});
      if (s1_sum[a] > half_c[a]) begin
        clamp_c[a] = half_c[a];
      end else if (s1_sum[a] < -half_c[a]) begin
        clamp_c[a] = -half_c[a];
      end else begin
        clamp_c[a] = s1_sum[a];
      end
      shift_c[a] = clamp_c[a] + half_c[a];
    end
  end

  logic              s2_clear;
  pib_fix_t          s2_pos   [AXES];
  pib_fix_t          s2_vel   [AXES];
  logic [DATA_W-1:0] s2_shift [AXES];

  // Stage 3: scale into grid units and clamp the upper edge.
  logic [PROD_W-1:0]  prod_c  [AXES];
  logic [DATA_W-1:0]  craw_c  [AXES];
  logic [CW-1:0]      coord_c [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prod_c[a] = PROD_W'(s2_shift[a]) * PROD_W'(cell_scale[a]);
      craw_c[a] = prod_c[a][PROD_W-1:SCALE_W];
      if (craw_c[a] >= DATA_W'(AXIS_CELLS[a])) begin
        coord_c[a] = CW'(AXIS_CELLS[a] - 1);
      end else begin
        coord_c[a] = craw_c[a][CW-1:0];
      end
    end
  end

  logic          s3_clear;
  pib_fix_t      s3_pos   [AXES];
  pib_fix_t      s3_vel   [AXES];
  logic [CW-1:0] s3_coord [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_clear <= particle.mode;
      s2_clear <= s1_clear;
      s3_clear <= s2_clear;
      for (int a = 0; a < AXES; a++) begin
        s1_sum[a]   <= sum_c[a];
        s1_vel[a]   <= vprod_c[a][DAMP_SHIFT +: DATA_W];
        s2_pos[a]   <= clamp_c[a][DATA_W-1:0];
        s2_shift[a] <= shift_c[a][DATA_W-1:0];
        s2_vel[a]   <= s1_vel[a];
        s3_pos[a]   <= s2_pos[a];
        s3_vel[a]   <= s2_vel[a];
        s3_coord[a] <= coord_c[a];
      end
    end
  end

  // Linear cell index, wrapped to the size of the histogram.
  logic [CALC_W-1:0] lin;

  assign lin = CALC_W'(s3_coord[0])
             + CALC_W'(s3_coord[1]) * CALC_W'(CELLS_X)
             + CALC_W'(s3_coord[2]) * CALC_W'(CELLS_X * CELLS_Y);

  always_comb begin
    q_item.clear = s3_clear;
    q_item.idx   = lin[CELL_IDX_W-1:0];
    for (int a = 0; a < AXES; a++) begin
      q_item.pos[a] = s3_pos[a];
      q_item.vel[a] = s3_vel[a];
    end
  end

endmodule

`default_nettype wire

/* rtl/pib_fifo.sv */
// ----------------------------------------------------------------------------
// Particle integrate-and-bin: item queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pib_fifo import pib_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pib_item_t push_item,
  output logic      push_ready,
  input  logic      pop,
  output logic      pop_valid,
  output pib_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pib_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/pib_back.sv */
// ----------------------------------------------------------------------------
// Particle integrate-and-bin: histogram back end
// Read-modify-write of the per-cell counts with epoch-tagged entries, write
// forwarding, the clearing sweep and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pib_back import pib_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  pib_item_t  q_item,
  output logic       q_pop,
  output logic       sweep_busy,
  pib_out_if.source  result
);

  localparam int ADDR_W = $clog2(NUM_ENTRIES);

  typedef enum logic {ST_SWEEP, ST_RUN} state_t;

  state_t            state;
  logic [ADDR_W-1:0] sweep_addr;
  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] epoch_next;

  pib_entry_t        mem [NUM_ENTRIES];
  pib_entry_t        rd_data;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  pib_entry_t        wdata;

  logic              b1_valid;
  pib_item_t         b1_item;
  logic              b1_fire;
  logic              b1_free;

  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_idx;
  logic [COUNT_W-1:0] fwd_count;

  logic              out_valid;
  pib_fix_t          out_pos [AXES];
  pib_fix_t          out_vel [AXES];
  logic [CELL_IDX_W-1:0] out_idx;
  logic [COUNT_W-1:0] out_count;

  logic              pop_particle;
  logic              pop_clear;
  logic [COUNT_W-1:0] base_count;
  logic [COUNT_W-1:0] count_new;

  assign sweep_busy   = state == ST_SWEEP;
  assign b1_fire      = b1_valid && (!out_valid || result.ready);
  assign b1_free      = !b1_valid || b1_fire;
  assign q_pop        = (state == ST_RUN) && q_valid && b1_free;
  assign pop_particle = q_pop && !q_item.clear;
  assign pop_clear    = q_pop && q_item.clear;
  assign epoch_next   = epoch + 1'b1;

  // The previous write lands at the same edge as this item's read, so its
  // value is taken from the forwarding register instead of the memory.
  always_comb begin
    if (fwd_valid && fwd_idx == b1_item.idx) begin
      base_count = fwd_count;
    end else if (rd_data.tag == epoch) begin
      base_count = rd_data.count;
    end else begin
      base_count = '0;
    end
    count_new = (&base_count) ? base_count : base_count + 1'b1;
  end

  always_comb begin
    if (state == ST_SWEEP) begin
      we          = 1'b1;
      waddr       = sweep_addr;
      wdata.tag   = epoch;
      wdata.count = '0;
    end else begin
      we          = b1_fire;
      waddr       = b1_item.idx;
      wdata.tag   = epoch;
      wdata.count = count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_particle) begin
      rd_data <= mem[q_item.idx];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      epoch      <= '0;
      b1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fwd_valid  <= 1'b0;
    end else begin
      if (pop_particle) begin
        b1_item <= q_item;
      end
      if (b1_free) begin
        b1_valid <= pop_particle;
      end

      if (b1_fire) begin
        out_valid <= 1'b1;
        out_pos   <= '{b1_item.pos[0], b1_item.pos[1], b1_item.pos[2]};
        out_vel   <= '{b1_item.vel[0], b1_item.vel[1], b1_item.vel[2]};
        out_idx   <= b1_item.idx;
        out_count <= count_new;
        fwd_idx   <= b1_item.idx;
        fwd_count <= count_new;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      // A forwarded count only stands within the frame it was written in.
      if (sweep_busy || pop_clear) begin
        fwd_valid <= 1'b0;
      end else if (b1_fire) begin
        fwd_valid <= 1'b1;
      end

      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (&sweep_addr) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (pop_clear) begin
            epoch <= epoch_next;
            if (epoch_next == '0) begin
              state <= ST_SWEEP;
            end
          end
        end
        default: state <= ST_SWEEP;
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.new_pos_x  = out_pos[0];
  assign result.new_pos_y  = out_pos[1];
  assign result.new_pos_z  = out_pos[2];
  assign result.new_vel_x  = out_vel[0];
  assign result.new_vel_y  = out_vel[1];
  assign result.new_vel_z  = out_vel[2];
  assign result.cell_index = out_idx;
  assign result.cell_count = out_count;

endmodule

`default_nettype wire

/* rtl/particle_integrate_and_bin.sv */
// ----------------------------------------------------------------------------
// Particle integrate-and-bin
// Euler step with velocity damping, per-axis clamp, grid binning and a
// saturating per-cell occupancy histogram.
// ----------------------------------------------------------------------------
// The block takes one particle transfer per clock on the particle channel
// when neither the queue nor the result channel holds it off and no sweep
// runs, and gives one result transfer per particle update; a frame-clear
// transfer gives no result. The front end (three register stages: add and
// damp, clamp and shift, 24x24 scale multiply) feeds a four-entry queue, and
// the back end does one histogram read-modify-write per cycle on a
// single-port-write, single-port-read count memory, so the sustained rate is
// one particle per cycle while the result channel is ready. Back-to-back hits
// on the same cell are forwarded. A frame clear is done by advancing an 8-bit
// epoch tag stored with each count, so entries of older frames read as zero.
// After reset, and after every 256th frame clear when the tag wraps, the back
// end sweeps all 4096 entries, one per cycle; during the sweep no particle
// transfer is accepted, while register writes are taken as usual. Registers
// should be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_integrate_and_bin import pib_pkg::*; #(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input  logic      clk,
  input  logic      rst,
  pib_in_if.sink    particle,
  pib_out_if.source result,
  pib_cfg_if.sink   cfg
);

  // Front end to queue.
  logic      q_push;
  logic      q_ready;
  pib_item_t push_item;

  // Queue to back end.
  logic      q_valid;
  logic      q_pop;
  pib_item_t pop_item;

  // The back end holds off new particles while it sweeps the histogram.
  logic      sweep_busy;

  pib_front #(
    .CELLS_X (CELLS_X),
    .CELLS_Y (CELLS_Y),
    .CELLS_Z (CELLS_Z)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .particle   (particle),
    .cfg        (cfg),
    .sweep_busy (sweep_busy),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  pib_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (pop_item)
  );

  pib_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .sweep_busy (sweep_busy),
    .result     (result)
  );

endmodule

`default_nettype wire
